// ----- sv/min_priority_job_queue_top_assert.svh -----
// assertion macros shared by the job queue modules
`ifndef MIN_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_JOB_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked on the rising edge, ignored while reset is held
`define MPJQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("mpjq assertion failed");

// property checked on every rising edge, reset included
`define MPJQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("mpjq assertion failed");

`else

`define MPJQ_ASSERT(name, clk, rstn, prop)
`define MPJQ_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ----- sv/mpjq_pkg.sv -----
package mpjq_pkg;

  // default sizes of the slot table
  localparam int DEPTH_DFLT          = 128;
  localparam int PAYLOAD_WIDTH_DFLT  = 32;
  localparam int PRIORITY_WIDTH_DFLT = 8;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load_req;   // latch the incoming word, clear the scan trackers
    logic clear_wr;   // write an empty slot at the sweep address
    logic scan_rd;    // read the slot at the sweep address
    logic commit;     // apply the update and load the result word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;  // sweep address is on the last slot
    logic skip;       // incoming word needs no scan
    logic out_free;   // result register can take a word this cycle
  } sts_t;

endpackage

// ----- sv/min_priority_job_queue_top.sv -----
// minimum priority job queue over a table of DEPTH slots
// input stream: each word carries action, job_priority and job_payload;
//   enqueue puts the job in the lowest free slot, dequeue and peek return
//   the occupied slot with the smallest priority (lowest index on a tie),
//   dequeue also frees it
// output stream: one word per input word with status, out_priority,
//   out_payload and the job count after the operation
// sweep: enqueue, dequeue and peek read every slot once, one slot per
//   cycle through the registered memory port, then commit the result; the
//   no-op code, a rejected enqueue and a lookup on an empty table skip the
//   sweep and go straight to commit
// one word is worked on at a time; the next is taken as soon as the
//   result sits in the output register
// reset: after rst_ni rises the table is swept empty, with s_axis_tready_o low
// stall: a held result keeps the next word in its final cycle until
//   m_axis_tready_i takes the pending one
module min_priority_job_queue_top #(
  parameter int DEPTH          = mpjq_pkg::DEPTH_DFLT,
  parameter int PAYLOAD_WIDTH  = mpjq_pkg::PAYLOAD_WIDTH_DFLT,
  parameter int PRIORITY_WIDTH = mpjq_pkg::PRIORITY_WIDTH_DFLT,
  localparam int InBits   = mpjq_pkg::ACTION_W + PRIORITY_WIDTH + PAYLOAD_WIDTH,
  localparam int InDataW  = ((InBits + 7) / 8) * 8,
  localparam int OutBits  = mpjq_pkg::STATUS_W + PRIORITY_WIDTH + PAYLOAD_WIDTH
                          + mpjq_pkg::COUNT_W,
  localparam int OutDataW = ((OutBits + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // action, job_priority, job_payload
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // status, out_priority, out_payload, job_count
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int PriLo = mpjq_pkg::ACTION_W;
  localparam int PayLo = PriLo + PRIORITY_WIDTH;

  logic [mpjq_pkg::ACTION_W-1:0] action;
  logic [PRIORITY_WIDTH-1:0]     job_priority;
  logic [PAYLOAD_WIDTH-1:0]      job_payload;
  logic [mpjq_pkg::STATUS_W-1:0] status;
  logic [PRIORITY_WIDTH-1:0]     out_priority;
  logic [PAYLOAD_WIDTH-1:0]      out_payload;
  logic [mpjq_pkg::COUNT_W-1:0]  job_count;
  mpjq_pkg::cmd_t                cmd;
  mpjq_pkg::sts_t                sts;

  // unpack input word
  assign action       = s_axis_tdata_i[mpjq_pkg::ACTION_W-1:0];
  assign job_priority = s_axis_tdata_i[PayLo-1:PriLo];
  assign job_payload  = s_axis_tdata_i[PayLo+PAYLOAD_WIDTH-1:PayLo];

  mpjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpjq_dp #(
    .DEPTH          (DEPTH),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action),
    .job_priority_i (job_priority),
    .job_payload_i  (job_payload),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .status_o       (status),
    .out_priority_o (out_priority),
    .out_payload_o  (out_payload),
    .job_count_o    (job_count)
  );

  // pack result word, zero filled to whole bytes
  assign m_axis_tdata_o = OutDataW'({job_count, out_payload, out_priority, status});

endmodule

// ----- sv/mpjq_ctrl.sv -----
`include "min_priority_job_queue_top_assert.svh"

module mpjq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mpjq_pkg::sts_t sts_i,
  output mpjq_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_WAIT   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // state register, the table is swept clear after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = sts_i.skip ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.addr_last) state_d = S_WAIT;
      end
      // last read word is compared here
      S_WAIT: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  `MPJQ_ASSERT(a_commit_needs_room, clk_i, rst_ni, cmd_o.commit |-> sts_i.out_free)
  `MPJQ_ASSERT(a_scan_ends_in_wait, clk_i, rst_ni, (state_q == S_SCAN && sts_i.addr_last) |=> (state_q == S_WAIT))

endmodule

// ----- sv/mpjq_dp.sv -----
`include "min_priority_job_queue_top_assert.svh"

module mpjq_dp #(
  parameter int DEPTH          = mpjq_pkg::DEPTH_DFLT,
  parameter int PAYLOAD_WIDTH  = mpjq_pkg::PAYLOAD_WIDTH_DFLT,
  parameter int PRIORITY_WIDTH = mpjq_pkg::PRIORITY_WIDTH_DFLT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // incoming word fields
  input  logic [mpjq_pkg::ACTION_W-1:0]    action_i,
  input  logic [PRIORITY_WIDTH-1:0]        job_priority_i,
  input  logic [PAYLOAD_WIDTH-1:0]         job_payload_i,
  input  mpjq_pkg::cmd_t                   cmd_i,
  output mpjq_pkg::sts_t                   sts_o,
  // result register
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mpjq_pkg::STATUS_W-1:0]    status_o,
  output logic [PRIORITY_WIDTH-1:0]        out_priority_o,
  output logic [PAYLOAD_WIDTH-1:0]         out_payload_o,
  output logic [mpjq_pkg::COUNT_W-1:0]     job_count_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // slot tables
  logic [PRIORITY_WIDTH-1:0] pri_mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  pay_mem [DEPTH];

  logic [IDX_W-1:0]          addr_q;
  logic                      addr_last;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      full;

  mpjq_pkg::action_e         in_act;
  mpjq_pkg::action_e         req_act_q;
  logic [PRIORITY_WIDTH-1:0] req_pri_q;
  logic [PAYLOAD_WIDTH-1:0]  req_pay_q;

  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic [PRIORITY_WIDTH-1:0] rd_pri_q;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay_q;

  logic                      best_vld_q, free_vld_q;
  logic [IDX_W-1:0]          best_idx_q, free_idx_q;
  logic [PRIORITY_WIDTH-1:0] best_pri_q;
  logic [PAYLOAD_WIDTH-1:0]  best_pay_q;
  logic                      take_best, take_free;

  logic                      enq_ok, deq_hit, lookup;
  logic                      pri_we, pay_we;
  logic [IDX_W-1:0]          wr_addr;
  logic [PRIORITY_WIDTH-1:0] wr_pri;
  mpjq_pkg::status_e         res_status;
  logic [CNT_W+mpjq_pkg::COUNT_W-1:0] count_wide;

  logic                      out_valid_q;
  mpjq_pkg::status_e         out_status_q;
  logic [PRIORITY_WIDTH-1:0] out_pri_q;
  logic [PAYLOAD_WIDTH-1:0]  out_pay_q;
  logic [mpjq_pkg::COUNT_W-1:0] out_cnt_q;

  assign in_act    = mpjq_pkg::action_e'(action_i);
  assign addr_last = (addr_q == IDX_W'(DEPTH - 1));
  assign full      = (count_q == CNT_W'(DEPTH));

  // status to the controller; skip marks words that finish without a sweep
  assign sts_o.addr_last = addr_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.skip      = (in_act == mpjq_pkg::ACT_NOP)
                        || (in_act == mpjq_pkg::ACT_ENQ && (job_priority_i == '0 || full))
                        || ((in_act == mpjq_pkg::ACT_DEQ || in_act == mpjq_pkg::ACT_PEEK)
                            && count_q == '0);

  // sweep address, shared by the clear pass and the scans
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.clear_wr || cmd_i.scan_rd) begin
      addr_q <= addr_last ? '0 : addr_q + 1'b1;
    end
  end

  // latched request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_act_q <= in_act;
      req_pri_q <= job_priority_i;
      req_pay_q <= job_payload_i;
    end
  end

  // update decisions at commit
  assign enq_ok  = (req_act_q == mpjq_pkg::ACT_ENQ) && (req_pri_q != '0) && !full
                && free_vld_q;
  assign deq_hit = (req_act_q == mpjq_pkg::ACT_DEQ) && best_vld_q;
  assign lookup  = (req_act_q == mpjq_pkg::ACT_DEQ || req_act_q == mpjq_pkg::ACT_PEEK);

  assign pri_we  = cmd_i.clear_wr || (cmd_i.commit && (enq_ok || deq_hit));
  assign pay_we  = cmd_i.commit && enq_ok;
  assign wr_addr = cmd_i.clear_wr ? addr_q : (enq_ok ? free_idx_q : best_idx_q);
  assign wr_pri  = (cmd_i.commit && enq_ok) ? req_pri_q : '0;

  // slot memories, registered reads at the sweep address
  always_ff @(posedge clk_i) begin
    if (pri_we) pri_mem[wr_addr] <= wr_pri;
    if (pay_we) pay_mem[wr_addr] <= req_pay_q;
    rd_pri_q <= pri_mem[addr_q];
    rd_pay_q <= pay_mem[addr_q];
    rd_idx_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  // running minimum of occupied slots and first free slot
  assign take_best = rd_vld_q && (rd_pri_q != '0) && (!best_vld_q || rd_pri_q < best_pri_q);
  assign take_free = rd_vld_q && (rd_pri_q == '0) && !free_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
    end else if (cmd_i.load_req) begin
      best_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      if (take_best) best_vld_q <= 1'b1;
      if (take_free) free_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_idx_q <= rd_idx_q;
      best_pri_q <= rd_pri_q;
      best_pay_q <= rd_pay_q;
    end
    if (take_free) free_idx_q <= rd_idx_q;
  end

  // job count
  always_comb begin
    count_d = count_q;
    if (cmd_i.commit && enq_ok)  count_d = count_q + 1'b1;
    if (cmd_i.commit && deq_hit) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result status
  always_comb begin
    unique case (req_act_q)
      mpjq_pkg::ACT_ENQ:  res_status = enq_ok ? mpjq_pkg::ST_OK : mpjq_pkg::ST_REJECT;
      mpjq_pkg::ACT_DEQ,
      mpjq_pkg::ACT_PEEK: res_status = best_vld_q ? mpjq_pkg::ST_OK : mpjq_pkg::ST_EMPTY;
      default:            res_status = mpjq_pkg::ST_OK;
    endcase
  end

  assign count_wide = (CNT_W + mpjq_pkg::COUNT_W)'(count_d);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_pri_q    <= (lookup && best_vld_q) ? best_pri_q : '0;
      out_pay_q    <= (lookup && best_vld_q) ? best_pay_q : '0;
      out_cnt_q    <= count_wide[mpjq_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_priority_o = out_pri_q;
  assign out_payload_o  = out_pay_q;
  assign job_count_o    = out_cnt_q;

  `MPJQ_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  `MPJQ_ASSERT(a_deq_drops_count, clk_i, rst_ni, (cmd_i.commit && deq_hit) |=> (count_q == $past(count_q) - 1'b1))

endmodule
